/* rtl/button_bank_debounce_events_core_defines.svh */
// Assertion macros shared by the RTL of the button bank debouncer.
`ifndef BUTTON_BANK_DEBOUNCE_EVENTS_CORE_DEFINES_SVH
`define BUTTON_BANK_DEBOUNCE_EVENTS_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is low.
`define BBDE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is low.
`define BBDE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BBDE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define BBDE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/bbde_pkg.sv */
package bbde_pkg;

    // Width of the mask registers and of the pin word.
    localparam int MASK_W = 8;
    // Width of the long-press threshold register.
    localparam int LONG_W = 16;
    // Reset value of the long-press threshold.
    localparam logic [LONG_W-1:0] LONG_RESET = 16'd100;

    // Event queue geometry.
    localparam int EVQ_DEPTH = 8;
    localparam int EVQ_PTR_W = $clog2(EVQ_DEPTH);
    localparam int EVQ_CNT_W = EVQ_PTR_W + 1;
    // Worst case of words still to land in the queue when a slot is issued.
    localparam int EVQ_RESERVE = 4;

    typedef enum logic [2:0] {
        EV_PRESS      = 3'd0,
        EV_RELEASE    = 3'd1,
        EV_CLICK      = 3'd2,
        EV_LONG_CLICK = 3'd3,
        EV_PRESS_LONG = 3'd4
    } t_evt_code;

    typedef enum logic [1:0] {
        CFG_ENABLED = 2'd0,
        CFG_INVERT  = 2'd1,
        CFG_LONG    = 2'd2
    } t_cfg_idx;

    // Events produced by one button in one tick.
    typedef struct packed {
        logic [1:0] num;
        t_evt_code  code0;
        t_evt_code  code1;
        logic       pressed;
    } t_evt_pair;

    // One queued event word.
    typedef struct packed {
        logic       last;
        logic       pressed;
        t_evt_code  code;
        logic [2:0] idx;
    } t_evq_word;

endpackage

/* rtl/button_bank_debounce_events_core.sv */
// Button bank debouncer. Each word on the slave stream is one sample tick that
// carries the raw pin levels of up to eight buttons (bit i is button i). For
// every enabled button the level is optionally inverted, debounced over two
// equal samples, and turned into PRESS, RELEASE, CLICK, LONG_CLICK and
// PRESS_LONG events, which leave on the master stream one word each, in button
// order, with tlast set on the final event of the tick (a tick with no events
// sends nothing). The per-button state (last sample, debounced level and hold
// counter) lives in a small synchronous RAM. A tick is processed by a scan
// that reads one button per cycle while the queue has room and writes it
// back the next cycle, followed by one closing slot that releases the
// held-back last event. The next tick is accepted in the same cycle as the
// closing slot of the current one, so ticks follow each other with no gap.
// The scan pauses whenever the eight-word event queue has fewer than four
// free words; since the master side takes one event per cycle while
// tready is high, a tick that raises many events (at most 16) is bounded by
// that drain. Enabling a button marks its entry as fresh in a flag register,
// and a fresh entry reads as released with a zero hold count until its next
// write; after reset every entry is fresh, so no clearing pass over the RAM
// is needed. Configuration writes are always taken and must only be issued
// while the block is idle.
`include "button_bank_debounce_events_core_defines.svh"

module button_bank_debounce_events_core #(
    parameter int NUM_BUTTONS = 8,
    parameter int COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Sample ticks. tdata: [7:0] pin_levels.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,
    // Events. tdata: [2:0] button_index, [5:3] event_code, [6] is_pressed,
    // [7] zero. tlast carries last_event.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,
    output logic        o_m_axis_tlast,
    // Register writes: 0 enabled_mask, 1 invert_mask, 2 long_press_ticks.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import bbde_pkg::*;

    localparam int IDX_W  = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int SLOT_W = $clog2(NUM_BUTTONS + 1);
    localparam int MB     = (NUM_BUTTONS < MASK_W) ? NUM_BUTTONS : MASK_W;
    localparam int ENT_W  = COUNT_WIDTH + 2;

    // Configuration registers.
    logic [MASK_W-1:0]      r_enabled;
    logic [MASK_W-1:0]      r_invert;
    logic [LONG_W-1:0]      r_long;
    logic [NUM_BUTTONS-1:0] r_fresh;
    logic [NUM_BUTTONS-1:0] newly_on;
    logic                   cfg_we;

    // Scan control.
    logic                   r_busy;
    logic [SLOT_W-1:0]      r_slot;
    logic [MASK_W-1:0]      r_pins;
    logic                   issue_ok;
    logic                   issue;
    logic                   last_slot;
    logic                   in_accept;
    logic [31:0]            slot_ext;
    logic                   slot_en;
    logic                   slot_sample;

    // State RAM: {first sample, debounced level, hold count}.
    logic [ENT_W-1:0]       r_ram [NUM_BUTTONS];
    logic [ENT_W-1:0]       r_rd;

    // Update stage.
    logic                   r_s1_valid;
    logic                   r_s1_flush;
    logic [IDX_W-1:0]       r_s1_idx;
    logic                   r_s1_en;
    logic                   r_s1_sample;
    logic [ENT_W-1:0]       cur_ent;
    logic                   upd_first;
    logic                   upd_deb;
    logic [COUNT_WIDTH-1:0] upd_count;
    t_evt_pair              upd_evt;
    logic                   s1_write;

    // Held-back event and queue pushes.
    logic                   r_pend_valid;
    t_evq_word              r_pend;
    logic                   n_pend_valid;
    t_evq_word              n_pend;
    t_evq_word              ev0;
    t_evq_word              ev1;
    logic                   push0;
    logic                   push1;
    t_evq_word              word0;
    t_evq_word              word1;
    t_evq_word              evq_word;
    logic [EVQ_CNT_W-1:0]   evq_level;

    // ---------------------------------------------------------------
    // Configuration. A button that goes from disabled to enabled is marked
    // fresh, which makes its RAM entry read as released on its next slot.
    // ---------------------------------------------------------------
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;

    always_comb begin
        newly_on         = '0;
        newly_on[MB-1:0] = i_cfg_data[MB-1:0] & ~r_enabled[MB-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= '0;
            r_invert  <= '0;
            r_long    <= LONG_RESET;
            r_fresh   <= '1;
        end else begin
            if (cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ENABLED: begin
                        r_enabled <= i_cfg_data[MASK_W-1:0];
                        r_fresh   <= r_fresh | newly_on;
                    end
                    CFG_INVERT: r_invert <= i_cfg_data[MASK_W-1:0];
                    CFG_LONG:   r_long   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (s1_write) begin
                r_fresh[r_s1_idx] <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Scan. Slots 0 to NUM_BUTTONS-1 read one button each; the slot equal to
    // NUM_BUTTONS is the closing slot. A slot is issued only when the queue
    // can absorb what this slot and the one ahead of it may still push.
    // The closing slot also keeps a read of an entry apart from its earlier
    // write, so the RAM needs no forwarding even for one button.
    // ---------------------------------------------------------------
    assign issue_ok        = (evq_level <= EVQ_CNT_W'(EVQ_DEPTH - EVQ_RESERVE));
    assign issue           = r_busy && issue_ok;
    assign last_slot       = (r_slot == SLOT_W'(NUM_BUTTONS));
    assign o_s_axis_tready = !r_busy || (last_slot && issue_ok);
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    assign slot_ext    = 32'(r_slot);
    assign slot_en     = (slot_ext < 32'(MASK_W)) && r_enabled[slot_ext[2:0]];
    assign slot_sample = r_pins[slot_ext[2:0]] ^ r_invert[slot_ext[2:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_slot     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= issue;
            if (in_accept) begin
                r_busy <= 1'b1;
                r_slot <= '0;
            end else if (issue && last_slot) begin
                r_busy <= 1'b0;
            end else if (issue) begin
                r_slot <= r_slot + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_pins <= i_s_axis_tdata;
        end
        if (issue) begin
            r_s1_flush  <= last_slot;
            r_s1_idx    <= r_slot[IDX_W-1:0];
            r_s1_en     <= slot_en;
            r_s1_sample <= slot_sample;
        end
    end

    // State RAM, one read and one write port.
    always_ff @(posedge i_clk) begin
        if (issue && !last_slot) begin
            r_rd <= r_ram[r_slot[IDX_W-1:0]];
        end
        if (s1_write) begin
            r_ram[r_s1_idx] <= {upd_first, upd_deb, upd_count};
        end
    end

    // ---------------------------------------------------------------
    // Update stage: compute the new state of the button and its events.
    // ---------------------------------------------------------------
    assign cur_ent  = r_fresh[r_s1_idx] ? '0 : r_rd;
    assign s1_write = r_s1_valid && !r_s1_flush && r_s1_en;

    bbde_btn_update #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_update (
        .i_en     (r_s1_valid && !r_s1_flush && r_s1_en),
        .i_sample (r_s1_sample),
        .i_first  (cur_ent[ENT_W-1]),
        .i_deb    (cur_ent[ENT_W-2]),
        .i_count  (cur_ent[COUNT_WIDTH-1:0]),
        .i_thr    (r_long),
        .o_first  (upd_first),
        .o_deb    (upd_deb),
        .o_count  (upd_count),
        .o_evt    (upd_evt)
    );

    // The newest event of a tick is always held back, because only the
    // closing slot tells whether it is the last one.
    always_comb begin
        ev0.last    = 1'b0;
        ev0.pressed = upd_evt.pressed;
        ev0.code    = upd_evt.code0;
        ev0.idx     = 3'(r_s1_idx);
        ev1.last    = 1'b0;
        ev1.pressed = upd_evt.pressed;
        ev1.code    = upd_evt.code1;
        ev1.idx     = 3'(r_s1_idx);

        push0        = 1'b0;
        push1        = 1'b0;
        word0        = r_pend;
        word1        = ev0;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        if (r_s1_valid) begin
            if (r_s1_flush) begin
                push0        = r_pend_valid;
                word0.last   = 1'b1;
                n_pend_valid = 1'b0;
            end else begin
                unique case (upd_evt.num)
                    2'd1: begin
                        push0        = r_pend_valid;
                        n_pend_valid = 1'b1;
                        n_pend       = ev0;
                    end
                    2'd2: begin
                        push0 = 1'b1;
                        if (r_pend_valid) begin
                            push1 = 1'b1;
                        end else begin
                            word0 = ev0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend       = ev1;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else begin
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
    end

    // ---------------------------------------------------------------
    // Event queue and master stream.
    // ---------------------------------------------------------------
    bbde_evt_fifo u_evq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (push0),
        .i_word0 (word0),
        .i_push1 (push1),
        .i_word1 (word1),
        .o_valid (o_m_axis_tvalid),
        .o_word  (evq_word),
        .i_ready (i_m_axis_tready),
        .o_level (evq_level)
    );

    assign o_m_axis_tdata = {1'b0, evq_word.pressed, evq_word.code, evq_word.idx};
    assign o_m_axis_tlast = evq_word.last;

    // ---------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------
    // A held-back event never outlives the scan of its tick.
    `BBDE_ASSERT_IMP(a_pend_only_in_scan, i_clk, i_rst_n, !r_busy && !r_s1_valid, !r_pend_valid, "held event left behind after scan")
    // An accepted tick starts its scan at the first button.
    `BBDE_ASSERT_NXT(a_tick_starts_scan, i_clk, i_rst_n, in_accept, r_busy && (r_slot == '0), "scan did not restart on accepted tick")
    // The issue credit keeps the event queue from overflowing.
    `BBDE_ASSERT_IMP(a_evq_no_overflow, i_clk, i_rst_n, 1'b1, evq_level <= EVQ_CNT_W'(EVQ_DEPTH), "event queue overflow")

endmodule

/* rtl/bbde_btn_update.sv */
module bbde_btn_update #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                   i_en,
    input  logic                   i_sample,
    input  logic                   i_first,
    input  logic                   i_deb,
    input  logic [COUNT_WIDTH-1:0] i_count,
    input  logic [15:0]            i_thr,
    output logic                   o_first,
    output logic                   o_deb,
    output logic [COUNT_WIDTH-1:0] o_count,
    output bbde_pkg::t_evt_pair    o_evt
);
    import bbde_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > LONG_W) ? COUNT_WIDTH : LONG_W;

    logic [COUNT_WIDTH-1:0] count_inc;
    logic [CMP_W-1:0]       count_x;
    logic [CMP_W-1:0]       inc_x;
    logic [CMP_W-1:0]       thr_x;

    assign count_inc = i_count + 1'b1;
    assign count_x   = CMP_W'(i_count);
    assign inc_x     = CMP_W'(count_inc);
    assign thr_x     = CMP_W'(i_thr);

    always_comb begin
        o_first     = i_first;
        o_deb       = i_deb;
        o_count     = i_count;
        o_evt.num   = 2'd0;
        o_evt.code0 = EV_PRESS;
        o_evt.code1 = EV_CLICK;
        if (i_en) begin
            if (i_sample != i_first) begin
                o_first = i_sample;
            end else if (i_sample != i_deb) begin
                o_deb = i_sample;
                if (i_sample) begin
                    o_count     = '0;
                    o_evt.num   = 2'd1;
                    o_evt.code0 = EV_PRESS;
                end else begin
                    o_evt.num   = 2'd2;
                    o_evt.code0 = EV_RELEASE;
                    o_evt.code1 = (count_x < thr_x) ? EV_CLICK : EV_LONG_CLICK;
                end
            end else if (i_deb && (i_count != '1)) begin
                o_count = count_inc;
                if (inc_x == thr_x) begin
                    o_evt.num   = 2'd1;
                    o_evt.code0 = EV_PRESS_LONG;
                end
            end
        end
        o_evt.pressed = o_deb;
    end

endmodule

/* rtl/bbde_evt_fifo.sv */
module bbde_evt_fifo (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push0,
    input  bbde_pkg::t_evq_word               i_word0,
    input  logic                              i_push1,
    input  bbde_pkg::t_evq_word               i_word1,
    output logic                              o_valid,
    output bbde_pkg::t_evq_word               o_word,
    input  logic                              i_ready,
    output logic [bbde_pkg::EVQ_CNT_W-1:0]    o_level
);
    import bbde_pkg::*;

    t_evq_word              r_mem [EVQ_DEPTH];
    logic [EVQ_PTR_W-1:0]   r_wp;
    logic [EVQ_PTR_W-1:0]   r_rp;
    logic [EVQ_CNT_W-1:0]   r_level;
    logic [EVQ_PTR_W-1:0]   wp_second;
    logic                   pop;
    logic [EVQ_CNT_W-1:0]   push_num;

    assign o_valid   = (r_level != '0);
    assign o_word    = r_mem[r_rp];
    assign o_level   = r_level;
    assign pop       = o_valid && i_ready;
    assign wp_second = r_wp + 1'b1;
    assign push_num  = EVQ_CNT_W'(i_push0) + EVQ_CNT_W'(i_push1);

    // The second word only ever comes together with the first one.
    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_mem[r_wp] <= i_word0;
        end
        if (i_push1) begin
            r_mem[wp_second] <= i_word1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_level <= '0;
        end else begin
            r_wp    <= r_wp + EVQ_PTR_W'(push_num);
            r_level <= r_level + push_num - EVQ_CNT_W'(pop);
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

endmodule
